### rtl/ssc_pkg.sv
// Package with the shared constants and the pipeline context type of the sphere contact block.
`default_nettype none
package ssc_pkg;

  // Default number of fraction bits of the fixed point format.
  localparam int FRAC_BITS_DEF = 16;

  // Widths fixed by the field formats.
  localparam int CW  = 32;          // coordinate width
  localparam int MW  = CW + 1;      // magnitude of a coordinate difference
  localparam int SW  = 2 * MW + 2;  // sum of three squares
  localparam int RTW = SW / 2;      // square root width
  localparam int NW  = 18;          // normal component width
  localparam int HW  = 16;          // handle and coefficient width

  // Configuration register indexes.
  localparam logic [7:0] REG_FRICTION    = 8'd0;
  localparam logic [7:0] REG_RESTITUTION = 8'd1;

  // Per-item context that travels beside the arithmetic.
  typedef struct packed {
    logic          vld;
    logic          ok;
    logic [2:0]    neg;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
    logic [CW-1:0] rsum;
    logic [HW-1:0] ba;
    logic [HW-1:0] bb;
    logic          hit;
    logic [CW-1:0] depth;
  } ctx_t;

endpackage
`default_nettype wire

### rtl/ssc_if.sv
// Channel interfaces of the sphere contact block: input pair, contact result and configuration.
`default_nettype none
interface ssc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_x;
  logic [31:0] first_y;
  logic [31:0] first_z;
  logic [30:0] first_radius;
  logic [31:0] second_x;
  logic [31:0] second_y;
  logic [31:0] second_z;
  logic [30:0] second_radius;
  logic [15:0] first_body;
  logic [15:0] second_body;
  logic [15:0] room_left;
  modport source (output valid, first_x, first_y, first_z, first_radius, second_x, second_y,
                  second_z, second_radius, first_body, second_body, room_left, input ready);
  modport sink (input valid, first_x, first_y, first_z, first_radius, second_x, second_y,
                second_z, second_radius, first_body, second_body, room_left, output ready);
endinterface

interface ssc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [17:0] normal_x;
  logic [17:0] normal_y;
  logic [17:0] normal_z;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  logic [31:0] depth;
  logic [15:0] body_a;
  logic [15:0] body_b;
  logic [15:0] contact_friction;
  logic [15:0] contact_restitution;
  modport source (output valid, hit, normal_x, normal_y, normal_z, point_x, point_y, point_z,
                  depth, body_a, body_b, contact_friction, contact_restitution, input ready);
  modport sink (input valid, hit, normal_x, normal_y, normal_z, point_x, point_y, point_z,
                depth, body_a, body_b, contact_friction, contact_restitution, output ready);
endinterface

interface ssc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/ssc_isqrt.sv
// Pipelined floor square root, one root bit per register stage.
`default_nettype none
module ssc_isqrt #(
  parameter int SW  = ssc_pkg::SW,
  parameter int RTW = SW / 2
) (
  input  wire logic           clk,
  input  wire logic           ce,
  input  wire logic [SW-1:0]  rad_i,
  output      logic [RTW-1:0] root_o
);

  logic [SW-1:0]  rad_w  [RTW+1];
  logic [RTW+1:0] rem_w  [RTW+1];
  logic [RTW-1:0] root_w [RTW+1];

  assign rad_w[0]  = rad_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  genvar k;
  generate
    for (k = 0; k < RTW; k++) begin : g_step
      logic [SW-1:0]  rad_r;
      logic [RTW+1:0] rem_r;
      logic [RTW-1:0] root_r;
      logic [RTW+1:0] rem_nxt;
      logic [RTW-1:0] root_nxt;
      logic [RTW+3:0] shifted;
      logic [RTW+3:0] trial;

      // Bring down two radicand bits and try a one in the next root bit.
      always_comb begin
        shifted = {rem_w[k], rad_w[k][SW-1:SW-2]};
        trial   = {2'b00, root_w[k], 2'b01};
        if (shifted >= trial) begin
          rem_nxt  = RTW'(0) + (RTW+2)'(shifted - trial);
          root_nxt = {root_w[k][RTW-2:0], 1'b1};
        end else begin
          rem_nxt  = shifted[RTW+1:0];
          root_nxt = {root_w[k][RTW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (ce) begin
          rad_r  <= rad_w[k] << 2;
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
        end
      end

      assign rad_w[k+1]  = rad_r;
      assign rem_w[k+1]  = rem_r;
      assign root_w[k+1] = root_r;
    end
  endgenerate

  assign root_o = root_w[RTW];

endmodule
`default_nettype wire

### rtl/ssc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module ssc_div #(
  parameter int DW = ssc_pkg::RTW,
  parameter int QW = ssc_pkg::FRAC_BITS_DEF + 1
) (
  input  wire logic          clk,
  input  wire logic          ce,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic          bit0_i,
  input  wire logic [DW-1:0] den_i,
  output      logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_w [QW+1];
  logic [DW-1:0] den_w [QW+1];
  logic [QW-1:0] quo_w [QW+1];

  assign rem_w[0] = rem_i;
  assign den_w[0] = den_i;
  assign quo_w[0] = '0;

  genvar j;
  generate
    for (j = 0; j < QW; j++) begin : g_step
      logic [DW-1:0] rem_r;
      logic [DW-1:0] den_r;
      logic [QW-1:0] quo_r;
      logic [DW:0]   shifted;
      logic [DW-1:0] rem_nxt;
      logic [QW-1:0] quo_nxt;
      logic          bit_in;

      // Only the first step takes a numerator bit that is not zero.
      assign bit_in = (j == 0) ? bit0_i : 1'b0;

      always_comb begin
        shifted = {rem_w[j], bit_in};
        if (shifted >= {1'b0, den_w[j]}) begin
          rem_nxt = DW'(shifted - {1'b0, den_w[j]});
          quo_nxt = {quo_w[j][QW-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[DW-1:0];
          quo_nxt = {quo_w[j][QW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r <= rem_nxt;
          den_r <= den_w[j];
          quo_r <= quo_nxt;
        end
      end

      assign rem_w[j+1] = rem_r;
      assign den_w[j+1] = den_r;
      assign quo_w[j+1] = quo_r;
    end
  endgenerate

  assign quo_o = quo_w[QW];

endmodule
`default_nettype wire

### rtl/sphere_sphere_contact.sv
// Top level of the sphere pair contact generator.
//
//   channel  direction  carries
//   in_ch    sink       two spheres, body handles, remaining room
//   out_ch   source     hit flag, normal, point, depth, handles, coefficients
//   cfg_ch   sink       register index and data (friction, restitution)
//
// One pair enters per cycle unless out_ch stalls; every pair gives exactly one
// result, after stages A to C, the one-bit-per-stage square root, stage D, the
// one-bit-per-stage divider and the output register. A stall on out_ch freezes
// the whole pipeline at once, so nothing is dropped or repeated. Reset clears the
// valid bits and the coefficient registers; the configuration port is always ready.
`default_nettype none
module sphere_sphere_contact #(
  parameter int FRAC_BITS = ssc_pkg::FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ssc_in_if.sink   in_ch,
  ssc_out_if.source out_ch,
  ssc_cfg_if.sink  cfg_ch
);

  localparam int CW  = ssc_pkg::CW;
  localparam int MW  = ssc_pkg::MW;
  localparam int SW  = ssc_pkg::SW;
  localparam int RTW = ssc_pkg::RTW;
  localparam int NW  = ssc_pkg::NW;
  localparam int HW  = ssc_pkg::HW;
  localparam int QW  = FRAC_BITS + 1;
  localparam int XW  = QW + NW;
  localparam logic [XW-1:0] NMAX = XW'((1 << (NW - 1)) - 1);

  logic ce;
  logic out_valid_r;

  // The pipeline advances whenever the output register is empty or being taken.
  assign ce          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = ce;

  // Configuration registers.
  logic [HW-1:0] friction_r;
  logic [HW-1:0] restitution_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      friction_r    <= '0;
      restitution_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == ssc_pkg::REG_FRICTION) begin
        friction_r <= cfg_ch.data;
      end
      if (cfg_ch.index == ssc_pkg::REG_RESTITUTION) begin
        restitution_r <= cfg_ch.data;
      end
    end
  end

  // Stage A: differences, magnitudes, contact point and radius sum.
  function automatic logic [CW-1:0] point_f(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic signed [CW+2:0] ae;
    logic signed [CW+2:0] be;
    logic signed [CW+2:0] v;
    logic signed [CW+2:0] h;
    ae = {{3{a[CW-1]}}, a};
    be = {{3{b[CW-1]}}, b};
    v  = (ae <<< 1) + ae - be;
    h  = v >>> 1;
    if (h[CW+2:CW-1] == '0 || h[CW+2:CW-1] == '1) begin
      point_f = h[CW-1:0];
    end else if (h[CW+2]) begin
      point_f = {1'b1, {(CW-1){1'b0}}};
    end else begin
      point_f = {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  function automatic logic [MW-1:0] diff_f(input logic [CW-1:0] a, input logic [CW-1:0] b);
    diff_f = {a[CW-1], a} - {b[CW-1], b};
  endfunction

  function automatic logic [MW-1:0] mag_f(input logic [MW-1:0] d);
    mag_f = d[MW-1] ? MW'(-d) : d;
  endfunction

  logic [MW-1:0] dx;
  logic [MW-1:0] dy;
  logic [MW-1:0] dz;
  ssc_pkg::ctx_t a_nxt;
  ssc_pkg::ctx_t a_r;
  logic [MW-1:0] ma_nxt [3];
  logic [MW-1:0] ma_r   [3];

  always_comb begin
    dx = diff_f(in_ch.first_x, in_ch.second_x);
    dy = diff_f(in_ch.first_y, in_ch.second_y);
    dz = diff_f(in_ch.first_z, in_ch.second_z);
    ma_nxt[0] = mag_f(dx);
    ma_nxt[1] = mag_f(dy);
    ma_nxt[2] = mag_f(dz);
    a_nxt       = '0;
    a_nxt.vld   = in_ch.valid;
    a_nxt.ok    = (in_ch.room_left != '0);
    a_nxt.neg   = {dz[MW-1], dy[MW-1], dx[MW-1]};
    a_nxt.px    = point_f(in_ch.first_x, in_ch.second_x);
    a_nxt.py    = point_f(in_ch.first_y, in_ch.second_y);
    a_nxt.pz    = point_f(in_ch.first_z, in_ch.second_z);
    a_nxt.rsum  = CW'(in_ch.first_radius) + CW'(in_ch.second_radius);
    a_nxt.ba    = in_ch.first_body;
    a_nxt.bb    = in_ch.second_body;
  end

  // Stage B: squares. Stage C: sum of squares.
  ssc_pkg::ctx_t b_r;
  ssc_pkg::ctx_t c_r;
  logic [MW-1:0]   mb_r [3];
  logic [MW-1:0]   mc_r [3];
  logic [2*MW-1:0] sq_r [3];
  logic [SW-1:0]   sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
      b_r.vld <= 1'b0;
      c_r.vld <= 1'b0;
    end else if (ce) begin
      a_r.vld <= a_nxt.vld;
      b_r.vld <= a_r.vld;
      c_r.vld <= b_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      {a_r.ok, a_r.neg, a_r.px, a_r.py, a_r.pz, a_r.rsum, a_r.ba, a_r.bb, a_r.hit, a_r.depth}
        <= {a_nxt.ok, a_nxt.neg, a_nxt.px, a_nxt.py, a_nxt.pz, a_nxt.rsum, a_nxt.ba,
            a_nxt.bb, a_nxt.hit, a_nxt.depth};
      {b_r.ok, b_r.neg, b_r.px, b_r.py, b_r.pz, b_r.rsum, b_r.ba, b_r.bb, b_r.hit, b_r.depth}
        <= {a_r.ok, a_r.neg, a_r.px, a_r.py, a_r.pz, a_r.rsum, a_r.ba, a_r.bb, a_r.hit,
            a_r.depth};
      {c_r.ok, c_r.neg, c_r.px, c_r.py, c_r.pz, c_r.rsum, c_r.ba, c_r.bb, c_r.hit, c_r.depth}
        <= {b_r.ok, b_r.neg, b_r.px, b_r.py, b_r.pz, b_r.rsum, b_r.ba, b_r.bb, b_r.hit,
            b_r.depth};
      for (int i = 0; i < 3; i++) begin
        ma_r[i] <= ma_nxt[i];
        mb_r[i] <= ma_r[i];
        mc_r[i] <= mb_r[i];
        sq_r[i] <= ma_r[i] * ma_r[i];
      end
      sum_r <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
    end
  end

  // Square root pipeline with the context delayed alongside.
  logic [RTW-1:0] root;
  ssc_pkg::ctx_t  s_w [RTW+1];
  logic [MW-1:0]  ms_w [RTW+1][3];

  ssc_isqrt #(.SW(SW), .RTW(RTW)) u_sqrt (
    .clk    (clk),
    .ce     (ce),
    .rad_i  (sum_r),
    .root_o (root)
  );

  assign s_w[0]  = c_r;
  assign ms_w[0] = mc_r;

  genvar k;
  generate
    for (k = 0; k < RTW; k++) begin : g_sdly
      ssc_pkg::ctx_t s_r;
      logic [MW-1:0] ms_r [3];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          s_r.vld <= 1'b0;
        end else if (ce) begin
          s_r.vld <= s_w[k].vld;
        end
      end
      always_ff @(posedge clk) begin
        if (ce) begin
          {s_r.ok, s_r.neg, s_r.px, s_r.py, s_r.pz, s_r.rsum, s_r.ba, s_r.bb, s_r.hit,
           s_r.depth} <= {s_w[k].ok, s_w[k].neg, s_w[k].px, s_w[k].py, s_w[k].pz,
                          s_w[k].rsum, s_w[k].ba, s_w[k].bb, s_w[k].hit, s_w[k].depth};
          ms_r <= ms_w[k];
        end
      end
      assign s_w[k+1]  = s_r;
      assign ms_w[k+1] = ms_r;
    end
  endgenerate

  // Stage D: hit decision, depth and divider set-up.
  ssc_pkg::ctx_t  d_nxt;
  ssc_pkg::ctx_t  d_r;
  logic [RTW-1:0] dist_r;
  logic [RTW-1:0] drem_r [3];
  logic [2:0]     dbit_r;

  always_comb begin
    d_nxt       = s_w[RTW];
    d_nxt.hit   = s_w[RTW].ok && (root != '0) && (root < RTW'(s_w[RTW].rsum));
    d_nxt.depth = CW'(RTW'(s_w[RTW].rsum) - root);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (ce) begin
      d_r.vld <= d_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      {d_r.ok, d_r.neg, d_r.px, d_r.py, d_r.pz, d_r.rsum, d_r.ba, d_r.bb, d_r.hit, d_r.depth}
        <= {d_nxt.ok, d_nxt.neg, d_nxt.px, d_nxt.py, d_nxt.pz, d_nxt.rsum, d_nxt.ba,
            d_nxt.bb, d_nxt.hit, d_nxt.depth};
      dist_r <= root;
      for (int i = 0; i < 3; i++) begin
        drem_r[i] <= RTW'(ms_w[RTW][i] >> 1);
        dbit_r[i] <= ms_w[RTW][i][0];
      end
    end
  end

  // Divider lanes, one per normal component; the magnitude never exceeds the distance.
  logic [QW-1:0] quo [3];

  genvar l;
  generate
    for (l = 0; l < 3; l++) begin : g_lane
      ssc_div #(.DW(RTW), .QW(QW)) u_div (
        .clk    (clk),
        .ce     (ce),
        .rem_i  (drem_r[l]),
        .bit0_i (dbit_r[l]),
        .den_i  (dist_r),
        .quo_o  (quo[l])
      );
    end
  endgenerate

  ssc_pkg::ctx_t v_w [QW+1];
  assign v_w[0] = d_r;

  genvar m;
  generate
    for (m = 0; m < QW; m++) begin : g_vdly
      ssc_pkg::ctx_t v_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r.vld <= 1'b0;
        end else if (ce) begin
          v_r.vld <= v_w[m].vld;
        end
      end
      always_ff @(posedge clk) begin
        if (ce) begin
          {v_r.ok, v_r.neg, v_r.px, v_r.py, v_r.pz, v_r.rsum, v_r.ba, v_r.bb, v_r.hit,
           v_r.depth} <= {v_w[m].ok, v_w[m].neg, v_w[m].px, v_w[m].py, v_w[m].pz,
                          v_w[m].rsum, v_w[m].ba, v_w[m].bb, v_w[m].hit, v_w[m].depth};
        end
      end
      assign v_w[m+1] = v_r;
    end
  endgenerate

  // Sign and clamp the quotients to the normal range.
  function automatic logic [NW-1:0] norm_f(input logic neg, input logic [QW-1:0] q);
    logic [XW-1:0] qe;
    logic [XW-1:0] lim;
    qe  = XW'(q);
    lim = neg ? NMAX + XW'(1) : NMAX;
    if (qe > lim) begin
      qe = lim;
    end
    norm_f = neg ? NW'(-qe) : NW'(qe);
  endfunction

  ssc_pkg::ctx_t f_ctx;
  logic          f_hit;
  assign f_ctx = v_w[QW];
  assign f_hit = f_ctx.hit;

  // Output register; a pair without contact reports all zero fields.
  logic          hit_r;
  logic [NW-1:0] nx_r, ny_r, nz_r;
  logic [CW-1:0] px_r, py_r, pz_r, depth_r;
  logic [HW-1:0] ba_r, bb_r, fr_r, rs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= f_ctx.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      hit_r   <= f_hit;
      nx_r    <= f_hit ? norm_f(f_ctx.neg[0], quo[0]) : '0;
      ny_r    <= f_hit ? norm_f(f_ctx.neg[1], quo[1]) : '0;
      nz_r    <= f_hit ? norm_f(f_ctx.neg[2], quo[2]) : '0;
      px_r    <= f_hit ? f_ctx.px : '0;
      py_r    <= f_hit ? f_ctx.py : '0;
      pz_r    <= f_hit ? f_ctx.pz : '0;
      depth_r <= f_hit ? f_ctx.depth : '0;
      ba_r    <= f_hit ? f_ctx.ba : '0;
      bb_r    <= f_hit ? f_ctx.bb : '0;
      fr_r    <= f_hit ? friction_r : '0;
      rs_r    <= f_hit ? restitution_r : '0;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.hit                 = hit_r;
  assign out_ch.normal_x            = nx_r;
  assign out_ch.normal_y            = ny_r;
  assign out_ch.normal_z            = nz_r;
  assign out_ch.point_x             = px_r;
  assign out_ch.point_y             = py_r;
  assign out_ch.point_z             = pz_r;
  assign out_ch.depth               = depth_r;
  assign out_ch.body_a              = ba_r;
  assign out_ch.body_b              = bb_r;
  assign out_ch.contact_friction    = fr_r;
  assign out_ch.contact_restitution = rs_r;

endmodule
`default_nettype wire

### tb/sphere_sphere_contact_test.sv
// Self-checking testbench for the sphere pair contact generator.
`default_nettype none
module sphere_sphere_contact_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] ax, ay, az;
    logic [30:0] ra;
    logic [31:0] bx, by, bz;
    logic [30:0] rb;
    logic [15:0] ba, bb, room;
  } pair_t;

  typedef struct packed {
    logic        hit;
    logic [17:0] nx, ny, nz;
    logic [31:0] px, py, pz;
    logic [31:0] depth;
    logic [15:0] ba, bb, fr, re;
  } contact_t;

  // A directed row; has_exp marks rows whose result is typed in.
  typedef struct {
    pair_t    p;
    bit       has_exp;
    contact_t c;
  } row_t;

  localparam int LATENCY = 3 + 34 + 1 + (ssc_pkg::FRAC_BITS_DEF + 1) + 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  ssc_in_if  in_ch();
  ssc_out_if out_ch();
  ssc_cfg_if cfg_ch();

  sphere_sphere_contact dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                             .cfg_ch(cfg_ch));

  always #5 clk = ~clk;

  logic [15:0] friction_q = '0;
  logic [15:0] restitution_q = '0;
  contact_t    pending[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_off = 1'b0;
  row_t        rows[$];

  // Floor square root of a 68 bit value, one result bit at a time.
  function automatic logic [33:0] isqrt(logic [67:0] v);
    logic [33:0] r;
    logic [34:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = {1'b0, r} | (35'd1 << b);
      if ({1'b0, c} * {1'b0, c} <= {2'b0, v}) r = c[33:0];
    end
    return r;
  endfunction

  function automatic logic [17:0] unit_part(logic signed [33:0] d, logic [33:0] dlen);
    logic [63:0] m;
    longint q;
    m = d < 0 ? 64'(-d) : 64'(d);
    q = longint'((m << ssc_pkg::FRAC_BITS_DEF) / dlen);
    if (d < 0) q = -q;
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    return q[17:0];
  endfunction

  function automatic logic [31:0] mid_point(logic [31:0] f, logic [31:0] s);
    longint v;
    v = 3 * longint'($signed(f)) - longint'($signed(s));
    v = v >>> 1;
    if (v > 64'sd2147483647) v = 2147483647;
    if (v < -64'sd2147483648) v = -2147483648;
    return v[31:0];
  endfunction

  // Expected contact for one sphere pair.
  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    logic signed [33:0] dx, dy, dz;
    logic [67:0] sq;
    logic [33:0] dlen;
    logic [31:0] rsum;
    c = '0;
    if (p.room == 0) return c;
    dx = $signed(p.ax) - $signed(p.bx);
    dy = $signed(p.ay) - $signed(p.by);
    dz = $signed(p.az) - $signed(p.bz);
    // Sign-extend to the full square width before multiplying.
    sq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
    dlen = isqrt(sq);
    rsum = 32'(p.ra) + 32'(p.rb);
    if (dlen == 0 || dlen >= 34'(rsum)) return c;
    c.hit = 1'b1;
    c.nx = unit_part(dx, dlen);
    c.ny = unit_part(dy, dlen);
    c.nz = unit_part(dz, dlen);
    c.px = mid_point(p.ax, p.bx);
    c.py = mid_point(p.ay, p.by);
    c.pz = mid_point(p.az, p.bz);
    c.depth = rsum - dlen[31:0];
    c.ba = p.ba;
    c.bb = p.bb;
    c.fr = friction_q;
    c.re = restitution_q;
    return c;
  endfunction

  // Drive one pair and wait for its transaction; valid drops only while idling.
  task automatic send_pair(pair_t p);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.first_x, in_ch.first_y, in_ch.first_z, in_ch.first_radius} <= {p.ax, p.ay, p.az, p.ra};
    {in_ch.second_x, in_ch.second_y, in_ch.second_z, in_ch.second_radius}
      <= {p.bx, p.by, p.bz, p.rb};
    {in_ch.first_body, in_ch.second_body, in_ch.room_left} <= {p.ba, p.bb, p.room};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending.push_back(predict_contact(p));
  endtask

  // Register write, issued only while idle.
  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == ssc_pkg::REG_FRICTION) friction_q = val;
    else if (idx == ssc_pkg::REG_RESTITUTION) restitution_q = val;
    @(posedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    while (n < LATENCY + 4) begin
      @(posedge clk);
      n++;
    end
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(400000)) - 200000);
      default: return 32'($signed($urandom_range(20000000)) - 10000000);
    endcase
  endfunction

  // Random pair, mostly near each other so that hits are common.
  function automatic pair_t rnd_pair();
    pair_t p;
    p.ax = rnd_coord();
    p.ay = rnd_coord();
    p.az = rnd_coord();
    if ($urandom_range(9) < 7) begin
      p.bx = p.ax + 32'($signed($urandom_range(2000000)) - 1000000);
      p.by = p.ay + 32'($signed($urandom_range(2000000)) - 1000000);
      p.bz = p.az + 32'($signed($urandom_range(2000000)) - 1000000);
      if ($urandom_range(19) == 0) p.bx = p.ax;
      if ($urandom_range(19) == 0) p.by = p.ay;
    end else begin
      p.bx = $urandom;
      p.by = $urandom;
      p.bz = $urandom;
    end
    p.ra = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(1500000));
    p.rb = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(1500000));
    p.ba = $urandom;
    p.bb = $urandom;
    p.room = $urandom_range(9) == 0 ? 16'd0 : 16'($urandom);
    return p;
  endfunction

  function automatic pair_t mk(logic [31:0] ax, ay, az, logic [30:0] ra,
                               logic [31:0] bx, by, bz, logic [30:0] rb, logic [15:0] room);
    pair_t p;
    p = '{ax, ay, az, ra, bx, by, bz, rb, 16'hA5A5, 16'h5A5A, room};
    return p;
  endfunction

  // Result side: random backpressure and the comparison.
  always @(posedge clk) begin
    contact_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = '{out_ch.hit, out_ch.normal_x, out_ch.normal_y, out_ch.normal_z, out_ch.point_x,
              out_ch.point_y, out_ch.point_z, out_ch.depth, out_ch.body_a, out_ch.body_b,
              out_ch.contact_friction, out_ch.contact_restitution};
      if (pending.size() == 0) begin
        $display("%0t: unexpected contact %h", $time, got);
        errors++;
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
    out_ch.ready <= rst_n && !hold_off && !($urandom_range(99) < recv_idle);
  end

  // Long receiver hold-off so the pipeline fills and stalls the input.
  initial begin
    int n;
    n = 0;
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    while (n < 200) begin
      @(posedge clk);
      n++;
    end
    hold_off <= 1'b0;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    pair_t p;
    contact_t c;
    in_ch.valid = 1'b0;
    {in_ch.first_x, in_ch.first_y, in_ch.first_z, in_ch.first_radius} = '0;
    {in_ch.second_x, in_ch.second_y, in_ch.second_z, in_ch.second_radius} = '0;
    {in_ch.first_body, in_ch.second_body, in_ch.room_left} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: some no-hit rows have their result typed in and checked against the predictor; all rows are sent.
    rows.push_back('{mk(0, 0, 0, 100, 65536, 0, 0, 100, 5), 1, '0});
    rows.push_back('{mk(0, 0, 0, 31'h7FFFFFFF, 0, 0, 0, 31'h7FFFFFFF, 16'hFFFF), 1, '0});
    rows.push_back('{mk(65536, 0, 0, 0, 0, 0, 0, 65536, 1), 1, '0});
    rows.push_back('{mk(65536, 0, 0, 65536, 0, 0, 0, 65536, 0), 1, '0});
    rows.push_back('{mk(65536, 0, 0, 65536, 0, 0, 0, 65536, 1), 0, '0});
    rows.push_back('{mk(0, -65536, 0, 65536, 0, 0, 0, 65536, 16'hFFFF), 0, '0});
    rows.push_back('{mk(0, 0, 1, 1, 0, 0, 0, 1, 2), 0, '0});
    rows.push_back('{mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                        32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF, 1), 0, '0});
    rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF,
                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 1), 0, '0});
    rows.push_back('{mk(32'h7FFFFFFF, 0, 0, 31'h7FFFFFFF, 32'h7FFF0000, 0, 0, 0, 1), 0, '0});
    rows.push_back('{mk(32'h80000000, 0, 0, 31'h7FFFFFFF, 32'h80010000, 0, 0, 0, 1), 0, '0});
    rows.push_back('{mk(3, 4, 0, 10, 0, 0, 0, 0, 1), 0, '0});
    rows.push_back('{mk(-3, -4, -12, 100, 0, 0, 0, 0, 1), 0, '0});
    rows.push_back('{mk(1, 1, 1, 5, 0, 0, 0, 0, 7), 0, '0});
    foreach (rows[i]) begin
      p = rows[i].p;
      c = predict_contact(p);
      if (rows[i].has_exp && c !== rows[i].c) begin
        $display("%0t: mismatch expected %h actual %h (table row %0d)", $time, rows[i].c, c, i);
        errors++;
      end
      send_pair(p);
    end
    drain();

    // Four phases, each with its own coefficients; only the first two idle both sides at random.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(ssc_pkg::REG_FRICTION, 16'hFFFF);
          write_reg(ssc_pkg::REG_RESTITUTION, 16'h0000);
        end
        1: begin
          write_reg(ssc_pkg::REG_FRICTION, 16'h0000);
          write_reg(ssc_pkg::REG_RESTITUTION, 16'hFFFF);
        end
        2: begin
          write_reg(ssc_pkg::REG_FRICTION, $urandom);
          write_reg(ssc_pkg::REG_RESTITUTION, $urandom);
        end
        default: begin
          write_reg(8'd2, 16'h1234);
          write_reg(ssc_pkg::REG_FRICTION, 16'h0180);
          write_reg(ssc_pkg::REG_RESTITUTION, 16'h00C0);
        end
      endcase
      send_idle = ph == 0 ? 33 : ph == 1 ? 45 : 0;
      recv_idle = ph == 0 ? 45 : ph == 1 ? 33 : 0;
      for (int k = 0; k < 360; k++) send_pair(rnd_pair());
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
